// ===== sv/ffba_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package ffba_pkg;

  localparam int MAX_BLOCKS_DEF   = 64;
  localparam int PAGE_BYTES_DEF   = 4096;
  localparam int HEADER_BYTES_DEF = 9;

  localparam int          REGION_W     = 17;
  localparam logic [16:0] REGION_RESET = 17'd65536;
  localparam logic [16:0] REGION_MAX   = 17'd65536;

  // request codes
  localparam logic [1:0] REQ_ALLOC = 2'd0;
  localparam logic [1:0] REQ_FREE  = 2'd1;
  localparam logic [1:0] REQ_QUERY = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOFIT    = 2'd1;
  localparam logic [1:0] ST_NOTALLOC = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef enum logic [3:0] {
    S_INIT0,
    S_INIT1,
    S_IDLE,
    S_SCAN,
    S_SHUP,
    S_SPLIT,
    S_SHDN,
    S_MARK,
    S_RESP
  } ffba_state_t;

endpackage
`default_nettype wire

// ===== sv/ffba_table.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ffba_table #(
  parameter int Depth = ffba_pkg::MAX_BLOCKS_DEF,
  parameter int IW    = $clog2(ffba_pkg::MAX_BLOCKS_DEF)
) (
  input  wire logic          clk,
  input  wire logic [IW-1:0] rd_addr,
  output logic      [15:0]   rd_start,
  output logic               rd_free,
  input  wire logic          st_we,
  input  wire logic [IW-1:0] st_waddr,
  input  wire logic [15:0]   st_wdata,
  input  wire logic          fr_we,
  input  wire logic [IW-1:0] fr_waddr,
  input  wire logic          fr_wdata
);

  logic [15:0] st_mem [Depth];
  logic        fr_mem [Depth];

  // block start offsets
  always_ff @(posedge clk) begin
    if (st_we) begin
      st_mem[st_waddr] <= st_wdata;
    end
    rd_start <= st_mem[rd_addr];
  end

  // free marks
  always_ff @(posedge clk) begin
    if (fr_we) begin
      fr_mem[fr_waddr] <= fr_wdata;
    end
    rd_free <= fr_mem[rd_addr];
  end

endmodule
`default_nettype wire

// ===== sv/ffba_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ffba_ctrl #(
  parameter int MaxBlocks   = ffba_pkg::MAX_BLOCKS_DEF,
  parameter int PageBytes   = ffba_pkg::PAGE_BYTES_DEF,
  parameter int HeaderBytes = ffba_pkg::HEADER_BYTES_DEF,
  parameter int IW          = $clog2(ffba_pkg::MAX_BLOCKS_DEF)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [1:0]    req_type,
  input  wire logic [15:0]   alloc_size,
  input  wire logic [15:0]   address,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [16:0]   cfg_data,
  output logic               resp_valid,
  input  wire logic          resp_ready,
  output logic [1:0]         resp_status,
  output logic [15:0]        resp_uaddr,
  output logic [15:0]        resp_bsize,
  output logic [IW-1:0]      rd_addr,
  input  wire logic [15:0]   rd_start,
  input  wire logic          rd_free,
  output logic               st_we,
  output logic [IW-1:0]      st_waddr,
  output logic [15:0]        st_wdata,
  output logic               fr_we,
  output logic [IW-1:0]      fr_waddr,
  output logic               fr_wdata
);
  import ffba_pkg::*;

  localparam int          CW     = $clog2(MaxBlocks + 1);
  localparam logic [16:0] H17    = 17'(HeaderBytes);
  localparam logic [17:0] PMASK  = 18'(PageBytes - 1);
  localparam bit          PAGE_P2 = ((PageBytes & (PageBytes - 1)) == 0);
  localparam int          PL     = $clog2(PageBytes);
  localparam logic [CW-1:0] CNT_MAX = CW'(MaxBlocks);

  ffba_state_t state, state_next;

  logic [16:0]   region;
  logic [CW-1:0] count;
  logic [1:0]    req;
  logic [15:0]   size;
  logic [15:0]   addr;
  logic [IW-1:0] ra;
  logic          issue;
  logic          rvalid;
  logic [IW-1:0] rpos;
  logic [15:0]   curstart;
  logic          curfree;
  logic          prevfree;
  logic [IW-1:0] bidx;
  logic [IW-1:0] tgt;
  logic          markval;
  logic [1:0]    nshift;
  logic [15:0]   newstart;
  logic [1:0]    status;
  logic [15:0]   uaddr;
  logic [15:0]   bsize;

  // region rounding to whole pages with clamps
  logic [16:0] reg_nz;
  logic [17:0] reg_up;
  logic [17:0] reg_rnd;
  logic [16:0] reg_fin;
  logic [15:0] sent_start;

  assign reg_nz = (region == 17'd0) ? 17'd1 : region;
  assign reg_up = {1'b0, reg_nz} + PMASK;

  generate
    if (PAGE_P2) begin : g_p2
      assign reg_rnd = reg_up & ~PMASK;
    end else begin : g_gen
      // divide by the page size through a reciprocal multiply
      localparam logic [19:0] RECIP =
        20'(((64'd1 << (18 + PL)) / 64'(PageBytes)) + 64'd1);
      logic [37:0] pg_prod;
      logic [37:0] pg_quo;
      assign pg_prod = 38'(reg_up) * 38'(RECIP);
      assign pg_quo  = pg_prod >> (18 + PL);
      assign reg_rnd = 18'(pg_quo * 38'(PageBytes));
    end
  endgenerate

  always_comb begin
    if (reg_rnd > {1'b0, REGION_MAX}) begin
      reg_fin = REGION_MAX;
    end else begin
      reg_fin = reg_rnd[16:0];
    end
    if (reg_fin < (H17 << 1)) begin
      reg_fin = H17 << 1;
    end
  end
  assign sent_start = 16'(reg_fin - H17);

  // pair evaluation during the scan: current entry and next start
  logic [16:0] cur_user;
  logic [16:0] fs;
  logic [16:0] size_h;
  logic        pair;
  logic        last;
  logic        al_exact, al_split, own;
  logic        pf, nf;
  logic        ev_exact, ev_full, ev_split, ev_fmark, ev_fshift, ev_query, ev_miss;

  assign cur_user = {1'b0, curstart} + H17;
  assign fs       = {1'b0, rd_start} - cur_user;
  assign size_h   = {1'b0, size} + H17;
  assign pair     = (state == S_SCAN) && rvalid && (rpos != '0);
  assign last     = (CW'(rpos) == count - CW'(1));
  assign al_exact = curfree && (fs == {1'b0, size});
  assign al_split = curfree && (fs >= size_h);
  assign own      = !curfree && ({1'b0, addr} >= cur_user) && (addr < rd_start);
  assign pf       = (rpos != IW'(1)) && prevfree;
  assign nf       = ((CW'(rpos) + CW'(1)) < count) && rd_free;

  assign ev_exact  = pair && (req == REQ_ALLOC) && al_exact;
  assign ev_full   = pair && (req == REQ_ALLOC) && !al_exact && al_split && (count == CNT_MAX);
  assign ev_split  = pair && (req == REQ_ALLOC) && !al_exact && al_split && (count != CNT_MAX);
  assign ev_fmark  = pair && (req == REQ_FREE) && own && !pf && !nf;
  assign ev_fshift = pair && (req == REQ_FREE) && own && (pf || nf);
  assign ev_query  = pair && (req == REQ_QUERY) && own;
  assign ev_miss   = pair && last && !ev_exact && !ev_full && !ev_split &&
                     !(req != REQ_ALLOC && own);

  assign in_ready    = (state == S_IDLE) && !cfg_valid;
  assign cfg_ready   = (state == S_IDLE);
  assign resp_valid  = (state == S_RESP);
  assign resp_status = status;
  assign resp_uaddr  = uaddr;
  assign resp_bsize  = bsize;
  assign rd_addr     = ra;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_INIT0: state_next = S_INIT1;
      S_INIT1: state_next = S_IDLE;
      S_IDLE: begin
        if (cfg_valid) begin
          state_next = S_INIT0;
        end else if (in_valid) begin
          state_next = (req_type == REQ_ALLOC || req_type == REQ_FREE ||
                        req_type == REQ_QUERY) ? S_SCAN : S_RESP;
        end
      end
      S_SCAN: begin
        if (ev_exact || ev_full || ev_query || ev_miss) begin
          state_next = S_RESP;
        end else if (ev_split) begin
          state_next = S_SHUP;
        end else if (ev_fmark) begin
          state_next = S_MARK;
        end else if (ev_fshift) begin
          state_next = S_SHDN;
        end
      end
      S_SHUP: begin
        if (rvalid && rpos == bidx) begin
          state_next = S_SPLIT;
        end
      end
      S_SPLIT: state_next = S_MARK;
      S_SHDN: begin
        if (rvalid && last) begin
          state_next = S_MARK;
        end
      end
      S_MARK: state_next = S_RESP;
      S_RESP: begin
        if (resp_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // table writes
  always_comb begin
    st_we    = 1'b0;
    st_waddr = '0;
    st_wdata = '0;
    fr_we    = 1'b0;
    fr_waddr = '0;
    fr_wdata = 1'b0;
    case (state)
      S_INIT0: begin
        st_we    = 1'b1;
        fr_we    = 1'b1;
        fr_wdata = 1'b1;
      end
      S_INIT1: begin
        st_we    = 1'b1;
        st_waddr = IW'(1);
        st_wdata = sent_start;
        fr_we    = 1'b1;
        fr_waddr = IW'(1);
      end
      S_SCAN: begin
        if (ev_exact) begin
          fr_we    = 1'b1;
          fr_waddr = rpos - IW'(1);
        end
      end
      S_SHUP: begin
        if (rvalid) begin
          st_we    = 1'b1;
          st_waddr = rpos + IW'(1);
          st_wdata = rd_start;
          fr_we    = 1'b1;
          fr_waddr = rpos + IW'(1);
          fr_wdata = rd_free;
        end
      end
      S_SPLIT: begin
        st_we    = 1'b1;
        st_waddr = bidx;
        st_wdata = newstart;
        fr_we    = 1'b1;
        fr_waddr = bidx;
        fr_wdata = 1'b1;
      end
      S_SHDN: begin
        if (rvalid) begin
          st_we    = 1'b1;
          st_waddr = rpos - IW'(nshift);
          st_wdata = rd_start;
          fr_we    = 1'b1;
          fr_waddr = rpos - IW'(nshift);
          fr_wdata = rd_free;
        end
      end
      S_MARK: begin
        fr_we    = 1'b1;
        fr_waddr = tgt;
        fr_wdata = markval;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_INIT0;
      region <= REGION_RESET;
      count  <= CW'(2);
      issue  <= 1'b0;
      rvalid <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        S_INIT1: count <= CW'(2);
        S_IDLE: begin
          if (cfg_valid) begin
            region <= cfg_data;
          end else if (in_valid) begin
            ra     <= '0;
            issue  <= 1'b1;
            rvalid <= 1'b0;
          end
        end
        S_SCAN: begin
          rpos <= ra;
          if (ev_split) begin
            ra     <= IW'(count - CW'(1));
            issue  <= 1'b1;
            rvalid <= 1'b0;
          end else if (ev_fshift) begin
            ra     <= nf ? rpos + IW'(1) : rpos;
            issue  <= 1'b1;
            rvalid <= 1'b0;
          end else begin
            rvalid <= issue;
            if (issue) begin
              ra <= ra + IW'(1);
              if (CW'(ra) == count - CW'(1)) begin
                issue <= 1'b0;
              end
            end
          end
        end
        S_SHUP: begin
          rvalid <= issue;
          rpos   <= ra;
          if (issue) begin
            ra <= ra - IW'(1);
            if (ra == bidx) begin
              issue <= 1'b0;
            end
          end
        end
        S_SPLIT: count <= count + CW'(1);
        S_SHDN: begin
          rvalid <= issue;
          rpos   <= ra;
          if (issue) begin
            ra <= ra + IW'(1);
            if (CW'(ra) == count - CW'(1)) begin
              issue <= 1'b0;
            end
          end
          if (rvalid && last) begin
            count <= count - CW'(nshift);
          end
        end
        default: ;
      endcase
    end
  end

  // request payload and scan datapath
  always_ff @(posedge clk) begin
    if (state == S_IDLE && !cfg_valid && in_valid) begin
      req    <= req_type;
      size   <= alloc_size;
      addr   <= address;
      status <= ST_OK;
      uaddr  <= '0;
      bsize  <= '0;
    end
    if (state == S_SCAN && rvalid) begin
      if (rpos == '0) begin
        curstart <= rd_start;
        curfree  <= rd_free;
        prevfree <= 1'b0;
      end else begin
        curstart <= rd_start;
        curfree  <= rd_free;
        prevfree <= curfree;
      end
      if (ev_exact || ev_split) begin
        uaddr <= cur_user[15:0];
      end
      if (ev_full) begin
        status <= ST_FULL;
      end
      if (ev_split) begin
        bidx     <= rpos;
        newstart <= 16'(cur_user + {1'b0, size});
        tgt      <= rpos - IW'(1);
        markval  <= 1'b0;
      end
      if (ev_fmark || ev_fshift) begin
        tgt     <= pf ? rpos - IW'(2) : rpos - IW'(1);
        markval <= 1'b1;
        nshift  <= {1'b0, pf} + {1'b0, nf};
      end
      if (ev_query) begin
        bsize <= fs[15:0];
      end
      if (ev_miss) begin
        status <= (req == REQ_ALLOC) ? ST_NOFIT : ST_NOTALLOC;
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/first_fit_block_allocator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel | Handshake               | Payload
// in      | in_valid / in_ready     | req_type, alloc_size, address
// out     | out_valid / out_ready   | status, user_address, block_size
// cfg     | cfg_valid / cfg_ready   | region_bytes
//
// A request walks the block table through the single read port of the table
// memory, one entry a cycle. A split then shifts entries up and writes the new
// entry and free mark; a merge shifts entries down and writes the free mark.
// Reset and every region write pass through S_INIT0 and S_INIT1, writing the
// first two entries. A finished result sits in the output register; the next
// request is taken once the result has been loaded there.
module first_fit_block_allocator #(
  parameter int MaxBlocks   = ffba_pkg::MAX_BLOCKS_DEF,
  parameter int PageBytes   = ffba_pkg::PAGE_BYTES_DEF,
  parameter int HeaderBytes = ffba_pkg::HEADER_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  req_type,
  input  wire logic [15:0] alloc_size,
  input  wire logic [15:0] address,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       status,
  output logic [15:0]      user_address,
  output logic [15:0]      block_size,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [16:0] region_bytes
);
  import ffba_pkg::*;

  localparam int IW = $clog2(MaxBlocks);

  logic          resp_valid, resp_ready;
  logic [1:0]    resp_status;
  logic [15:0]   resp_uaddr, resp_bsize;
  logic [IW-1:0] rd_addr, st_waddr, fr_waddr;
  logic [15:0]   rd_start, st_wdata;
  logic          rd_free, st_we, fr_we, fr_wdata;

  ffba_ctrl #(
    .MaxBlocks(MaxBlocks), .PageBytes(PageBytes), .HeaderBytes(HeaderBytes), .IW(IW)
  ) u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .req_type, .alloc_size, .address,
    .cfg_valid, .cfg_ready, .cfg_data(region_bytes),
    .resp_valid, .resp_ready, .resp_status, .resp_uaddr, .resp_bsize,
    .rd_addr, .rd_start, .rd_free, .st_we, .st_waddr, .st_wdata,
    .fr_we, .fr_waddr, .fr_wdata
  );

  ffba_table #(.Depth(MaxBlocks), .IW(IW)) u_table (
    .clk, .rd_addr, .rd_start, .rd_free, .st_we, .st_waddr, .st_wdata,
    .fr_we, .fr_waddr, .fr_wdata
  );

  assign resp_ready = !out_valid || out_ready;

  // hold the result until the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (resp_ready) begin
      out_valid <= resp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (resp_ready && resp_valid) begin
      status       <= resp_status;
      user_address <= resp_uaddr;
      block_size   <= resp_bsize;
    end
  end

endmodule
`default_nettype wire
